/* rtl/hnedec_pkg.sv */
`timescale 1ns / 1ps

package hnedec_pkg;

	localparam int unsigned JOB_DEPTH = 4;

	localparam logic [7:0] TERM_RESET = 8'h22;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;

	localparam logic [20:0] CP_LIMIT = 21'h110000;

	// One decoded job: up to four result words, the count less one, and
	// whether the final word of the job is the end-of-string marker.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      cnt_m1;
		logic            ends;
	} job_t;

endpackage

/* rtl/html_numeric_entity_utf8_decoder_core.sv */
`timescale 1ns / 1ps

// Streaming decoder for HTML numeric character references: string bytes go
// in one word per cycle and come out unchanged, except that '&#' digits ';'
// (decimal, or hexadecimal after 'x' or 'X') is replaced by its UTF-8
// encoding of one to four words, and a code point at or above 0x110000 by
// '?'. The byte held in the terminator register (reset 0x22) or a zero byte
// ends the string with a zero word marked end_of_string; last_result marks
// the final word caused by each input byte. The front end takes one input
// word every cycle while the job queue (JOB_DEPTH entries) has room, and a
// byte that only advances a reference pushes no job. The back end delivers
// one result word per cycle while the consumer pops, so a steady run of
// multi-word results is paced by that output path and the input sees full
// once the job queue has filled.
module html_numeric_entity_utf8_decoder_core #(
	parameter int unsigned JOB_DEPTH = hnedec_pkg::JOB_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       end_of_string,
	output logic       last_result
);

	hnedec_pkg::job_t wjob, rjob;
	logic             job_push, job_pop, job_full, job_empty;

	hnedec_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (push),
		.in_byte  (in_byte),
		.job_full (job_full),
		.in_full  (full),
		.job_push (job_push),
		.job      (wjob)
	);

	hnedec_job_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (wjob),
		.pop    (job_pop),
		.rdata  (rjob),
		.full   (job_full),
		.empty  (job_empty)
	);

	hnedec_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job           (rjob),
		.job_empty     (job_empty),
		.job_pop       (job_pop),
		.pop           (pop),
		.empty         (empty),
		.out_byte      (out_byte),
		.end_of_string (end_of_string),
		.last_result   (last_result)
	);

endmodule

/* rtl/hnedec_front.sv */
`timescale 1ns / 1ps

module hnedec_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_data,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	input  logic              job_full,
	output logic              in_full,
	output logic              job_push,
	output hnedec_pkg::job_t  job
);

	typedef enum logic [4:0] {
		MODE_PLAIN = 5'b00001,
		MODE_AMP   = 5'b00010,
		MODE_HASH  = 5'b00100,
		MODE_DEC   = 5'b01000,
		MODE_HEX   = 5'b10000
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [20:0] acc_q, acc_d;
	logic [7:0]  term_q;

	logic        accept;
	logic        is_end;
	logic        is_dec, is_hex_letter_lo, is_hex_letter_up;
	logic [3:0]  dec_val, hex_val;
	logic [24:0] next_dec, next_hex;
	logic [20:0] sat_dec, sat_hex;

	logic [3:0][7:0] enc_bytes;
	logic [1:0]      enc_cnt_m1;

	logic [1:0]  pre_n;
	logic        use_plain, use_enc;
	logic        pb_emit, pb_end;
	logic [7:0]  pb_byte;
	logic [2:0]  n_out;

	assign accept  = in_valid && !job_full;
	assign in_full = job_full;
	assign is_end  = (in_byte == 8'h00) || (in_byte == term_q);

	assign is_dec           = (in_byte >= 8'h30) && (in_byte <= 8'h39);
	assign is_hex_letter_lo = (in_byte >= 8'h61) && (in_byte <= 8'h66);
	assign is_hex_letter_up = (in_byte >= 8'h41) && (in_byte <= 8'h46);

	assign dec_val = in_byte[3:0];

	always_comb begin
		if (is_dec) begin
			hex_val = in_byte[3:0];
		end else begin
			// Letters a to f and A to F share the low three bits.
			hex_val = 4'(in_byte[2:0] + 3'd1) + 4'd8;
		end
	end

	// The accumulator saturates at the first value beyond the code space.
	assign next_dec = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {21'd0, dec_val};
	assign next_hex = {acc_q, 4'b0000} + {21'd0, hex_val};
	assign sat_dec  = (next_dec >= 25'(hnedec_pkg::CP_LIMIT)) ? hnedec_pkg::CP_LIMIT
		: next_dec[20:0];
	assign sat_hex  = (next_hex >= 25'(hnedec_pkg::CP_LIMIT)) ? hnedec_pkg::CP_LIMIT
		: next_hex[20:0];

	// UTF-8 encoding of the gathered code point.
	always_comb begin
		enc_bytes  = '0;
		enc_cnt_m1 = 2'd0;
		if (acc_q < 21'h80) begin
			enc_bytes[0] = acc_q[7:0];
		end else if (acc_q < 21'h800) begin
			enc_bytes[0] = 8'hC0 | {3'b000, acc_q[10:6]};
			enc_bytes[1] = 8'h80 | {2'b00, acc_q[5:0]};
			enc_cnt_m1   = 2'd1;
		end else if (acc_q < 21'h10000) begin
			enc_bytes[0] = 8'hE0 | {4'b0000, acc_q[15:12]};
			enc_bytes[1] = 8'h80 | {2'b00, acc_q[11:6]};
			enc_bytes[2] = 8'h80 | {2'b00, acc_q[5:0]};
			enc_cnt_m1   = 2'd2;
		end else if (acc_q < hnedec_pkg::CP_LIMIT) begin
			enc_bytes[0] = 8'hF0 | {5'b00000, acc_q[20:18]};
			enc_bytes[1] = 8'h80 | {2'b00, acc_q[17:12]};
			enc_bytes[2] = 8'h80 | {2'b00, acc_q[11:6]};
			enc_bytes[3] = 8'h80 | {2'b00, acc_q[5:0]};
			enc_cnt_m1   = 2'd3;
		end else begin
			enc_bytes[0] = hnedec_pkg::CH_QMARK;
		end
	end

	// Classification: a prefix of zero to two flushed words, then either
	// the plain handling of the byte or the encoded code point (or neither).
	always_comb begin
		mode_d    = mode_q;
		acc_d     = acc_q;
		pre_n     = 2'd0;
		use_plain = 1'b0;
		use_enc   = 1'b0;
		unique case (mode_q) inside
			MODE_AMP: begin
				if (!is_end && in_byte == hnedec_pkg::CH_HASH) begin
					mode_d = MODE_HASH;
					acc_d  = '0;
				end else begin
					pre_n     = 2'd1;
					use_plain = 1'b1;
				end
			end
			MODE_HASH, MODE_DEC, MODE_HEX: begin
				if (is_end) begin
					pre_n     = 2'd2;
					use_plain = 1'b1;
				end else if (in_byte == hnedec_pkg::CH_SEMI) begin
					use_enc = 1'b1;
					mode_d  = MODE_PLAIN;
					acc_d   = '0;
				end else if (mode_q == MODE_HASH && (in_byte == hnedec_pkg::CH_LOW_X
						|| in_byte == hnedec_pkg::CH_UP_X)) begin
					mode_d = MODE_HEX;
				end else if (mode_q == MODE_HEX
						&& (is_dec || is_hex_letter_lo || is_hex_letter_up)) begin
					acc_d = sat_hex;
				end else if (mode_q != MODE_HEX && is_dec) begin
					acc_d  = sat_dec;
					mode_d = MODE_DEC;
				end else begin
					pre_n     = 2'd2;
					use_plain = 1'b1;
				end
			end
			default: begin
				use_plain = 1'b1;
			end
		endcase

		pb_emit = 1'b0;
		pb_end  = 1'b0;
		pb_byte = in_byte;
		if (use_plain) begin
			acc_d = '0;
			if (is_end) begin
				mode_d  = MODE_PLAIN;
				pb_emit = 1'b1;
				pb_end  = 1'b1;
				pb_byte = 8'h00;
			end else if (in_byte == hnedec_pkg::CH_AMP) begin
				mode_d = MODE_AMP;
			end else begin
				mode_d  = MODE_PLAIN;
				pb_emit = 1'b1;
			end
		end
	end

	always_comb begin
		job       = '0;
		n_out     = {1'b0, pre_n} + {2'b00, pb_emit};
		if (use_enc) begin
			job.bytes  = enc_bytes;
			job.cnt_m1 = enc_cnt_m1;
			job_push   = accept;
		end else begin
			job.bytes[0] = hnedec_pkg::CH_AMP;
			job.bytes[1] = hnedec_pkg::CH_HASH;
			case (pre_n)
				2'd0:    job.bytes[0] = pb_byte;
				2'd1:    job.bytes[1] = pb_byte;
				default: job.bytes[2] = pb_byte;
			endcase
			job.cnt_m1 = 2'(n_out - 3'd1);
			job.ends   = pb_end;
			job_push   = accept && (n_out != 3'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			acc_q  <= '0;
			term_q <= hnedec_pkg::TERM_RESET;
		end else begin
			if (accept) begin
				mode_q <= mode_d;
				acc_q  <= acc_d;
			end
			if (cfg_we) begin
				term_q <= cfg_data;
			end
		end
	end

endmodule

/* rtl/hnedec_job_fifo.sv */
`timescale 1ns / 1ps

module hnedec_job_fifo #(
	parameter int unsigned DEPTH = hnedec_pkg::JOB_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hnedec_pkg::job_t  wdata,
	input  logic              pop,
	output hnedec_pkg::job_t  rdata,
	output logic              full,
	output logic              empty
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	hnedec_pkg::job_t    store_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/hnedec_back.sv */
`timescale 1ns / 1ps

module hnedec_back (
	input  logic              clk,
	input  logic              arst_n,
	input  hnedec_pkg::job_t  job,
	input  logic              job_empty,
	output logic              job_pop,
	input  logic              pop,
	output logic              empty,
	output logic [7:0]        out_byte,
	output logic              end_of_string,
	output logic              last_result
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       eos_q, last_q;
	logic       load, at_last;

	// The output register takes a waiting job word whenever it is free or
	// drained this cycle, so words stream at one per cycle while popped.
	assign load    = !job_empty && (!out_valid_q || pop);
	assign at_last = (idx_q == job.cnt_m1);
	assign job_pop = load && at_last;

	assign empty         = !out_valid_q;
	assign out_byte      = out_byte_q;
	assign end_of_string = eos_q;
	assign last_result   = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= job.bytes[idx_q];
			eos_q      <= at_last && job.ends;
			last_q     <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= at_last ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* test/tb_html_numeric_entity_utf8_decoder_core.sv */
`timescale 1ns / 1ps

module tb_html_numeric_entity_utf8_decoder_core;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 8;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_UP_A  = 8'h41;

	typedef enum logic [4:0] {
		SCAN_PLAIN = 5'b00001,
		SCAN_AMP   = 5'b00010,
		SCAN_HASH  = 5'b00100,
		SCAN_DEC   = 5'b01000,
		SCAN_HEX   = 5'b10000
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eos;
		logic       last;
	} result_word_t;

	// Tracks the decoder state and holds the words each accepted byte should produce.
	class decoder_scoreboard;
		scan_mode_t   mode;
		logic [20:0]  acc;
		logic [7:0]   term;
		result_word_t expected_words[$];
		result_word_t step_words[$];
		int           errors;
		int           checked;

		function new();
			mode    = SCAN_PLAIN;
			acc     = '0;
			term    = hnedec_pkg::TERM_RESET;
			errors  = 0;
			checked = 0;
		endfunction

		function void set_terminator(logic [7:0] v);
			term = v;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function bit ends_string(logic [7:0] b);
			return (b == 8'h00) || (b == term);
		endfunction

		function void put_word(logic [7:0] b, logic e);
			result_word_t w;
			w.data = b;
			w.eos  = e;
			w.last = 1'b0;
			step_words.push_back(w);
		endfunction

		function void plain_byte(logic [7:0] b);
			mode = SCAN_PLAIN;
			acc  = '0;
			if (ends_string(b)) begin
				put_word(8'h00, 1'b1);
			end else if (b == hnedec_pkg::CH_AMP) begin
				mode = SCAN_AMP;
			end else begin
				put_word(b, 1'b0);
			end
		endfunction

		function void abandon_reference(logic [7:0] b);
			put_word(hnedec_pkg::CH_AMP, 1'b0);
			put_word(hnedec_pkg::CH_HASH, 1'b0);
			plain_byte(b);
		endfunction

		function int digit_value(logic [7:0] b, bit hex);
			if (b >= CH_ZERO && b <= 8'h39)
				return int'(b - CH_ZERO);
			if (hex && b >= CH_LOW_A && b <= 8'h66)
				return int'(b - CH_LOW_A) + 10;
			if (hex && b >= CH_UP_A && b <= 8'h46)
				return int'(b - CH_UP_A) + 10;
			return 16;
		endfunction

		function void emit_code_point();
			logic [20:0] c;
			c = acc;
			if (c < 21'h80) begin
				put_word({1'b0, c[6:0]}, 1'b0);
			end else if (c < 21'h800) begin
				put_word({3'b110, c[10:6]}, 1'b0);
				put_word({2'b10, c[5:0]}, 1'b0);
			end else if (c < 21'h10000) begin
				put_word({4'b1110, c[15:12]}, 1'b0);
				put_word({2'b10, c[11:6]}, 1'b0);
				put_word({2'b10, c[5:0]}, 1'b0);
			end else if (c < hnedec_pkg::CP_LIMIT) begin
				put_word({5'b11110, c[20:18]}, 1'b0);
				put_word({2'b10, c[17:12]}, 1'b0);
				put_word({2'b10, c[11:6]}, 1'b0);
				put_word({2'b10, c[5:0]}, 1'b0);
			end else begin
				put_word(hnedec_pkg::CH_QMARK, 1'b0);
			end
			mode = SCAN_PLAIN;
			acc  = '0;
		endfunction

		function void note_byte(logic [7:0] b);
			bit          hex;
			int          d;
			logic [31:0] nxt;
			step_words.delete();
			case (mode) inside
				SCAN_AMP: begin
					if (!ends_string(b) && b == hnedec_pkg::CH_HASH) begin
						mode = SCAN_HASH;
						acc  = '0;
					end else begin
						put_word(hnedec_pkg::CH_AMP, 1'b0);
						plain_byte(b);
					end
				end
				SCAN_HASH, SCAN_DEC, SCAN_HEX: begin
					if (ends_string(b)) begin
						abandon_reference(b);
					end else if (b == hnedec_pkg::CH_SEMI) begin
						emit_code_point();
					end else if (mode == SCAN_HASH && (b == hnedec_pkg::CH_LOW_X
							|| b == hnedec_pkg::CH_UP_X)) begin
						mode = SCAN_HEX;
					end else begin
						hex = (mode == SCAN_HEX);
						d   = digit_value(b, hex);
						if (d < 16) begin
							nxt = 32'(acc) * (hex ? 32'd16 : 32'd10) + 32'(d);
							// The accumulator sticks at the limit once it gets there.
							acc = (nxt >= 32'(hnedec_pkg::CP_LIMIT)) ? hnedec_pkg::CP_LIMIT
								: nxt[20:0];
							if (!hex)
								mode = SCAN_DEC;
						end else begin
							abandon_reference(b);
						end
					end
				end
				default: plain_byte(b);
			endcase
			if (step_words.size() > 0)
				step_words[step_words.size() - 1].last = 1'b1;
			foreach (step_words[i])
				expected_words.push_back(step_words[i]);
		endfunction

		function void check_word(logic [7:0] data, logic eos, logic last);
			result_word_t w;
			checked++;
			if (expected_words.size() == 0) begin
				$error("unexpected result word: out_byte %h end_of_string %b last_result %b",
					data, eos, last);
				errors++;
				return;
			end
			w = expected_words.pop_front();
			if (data !== w.data) begin
				$error("out_byte: expected %h, got %h", w.data, data);
				errors++;
			end
			if (eos !== w.eos) begin
				$error("end_of_string: expected %b, got %b", w.eos, eos);
				errors++;
			end
			if (last !== w.last) begin
				$error("last_result: expected %b, got %b", w.last, last);
				errors++;
			end
		endfunction

		function void check_drained();
			if (expected_words.size() != 0) begin
				$error("%0d expected result words never arrived", expected_words.size());
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_data = 8'h00;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] in_byte = 8'h00;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_byte;
	logic       end_of_string;
	logic       last_result;

	decoder_scoreboard sb = new();

	bit allow_idle = 1'b1;
	int stall_left = 0;
	int idle_cycles = 0;
	int bytes_sent = 0;
	int settings_used = 1;

	html_numeric_entity_utf8_decoder_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.in_byte       (in_byte),
		.empty         (empty),
		.pop           (pop),
		.out_byte      (out_byte),
		.end_of_string (end_of_string),
		.last_result   (last_result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Result side: take the word at the head, then decide whether to stall next cycle.
	always @(posedge clk) begin
		if (pop && !empty)
			sb.check_word(out_byte, end_of_string, last_result);
		if (stall_left > 0) begin
			stall_left--;
			pop <= 1'b0;
		end else if (allow_idle && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 16);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("html_numeric_entity_utf8_decoder_core: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Leaves push high after the word is taken; the caller lowers it if nothing follows.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (allow_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (full);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_number(input int unsigned v, input bit hex);
		logic [7:0]  digits[$];
		int unsigned base;
		int unsigned r;
		int unsigned rest;
		int          zeros;
		base  = hex ? 16 : 10;
		rest  = v;
		zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (zeros) send_byte(CH_ZERO);
		do begin
			r    = rest % base;
			rest = rest / base;
			if (r < 10)
				digits.push_front(CH_ZERO + 8'(r));
			else if ($urandom_range(0, 1) != 0)
				digits.push_front(CH_LOW_A + 8'(r - 10));
			else
				digits.push_front(CH_UP_A + 8'(r - 10));
		end while (rest != 0);
		foreach (digits[i])
			send_byte(digits[i]);
	endtask

	task automatic send_x_marker();
		send_byte($urandom_range(0, 1) != 0 ? hnedec_pkg::CH_LOW_X : hnedec_pkg::CH_UP_X);
	endtask

	task automatic run_random_phase(input int quota);
		int          start;
		int          kind;
		int unsigned cp;
		bit          hex;
		start = bytes_sent;
		while (bytes_sent - start < quota) begin
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				hex = 1'($urandom_range(0, 1));
				case ($urandom_range(0, 4))
					0: cp = $urandom_range(0, 'h7F);
					1: cp = $urandom_range('h80, 'h7FF);
					2: cp = $urandom_range('h800, 'hFFFF);
					3: cp = $urandom_range('h10000, 'h10FFFF);
					default: cp = $urandom;
				endcase
				send_byte(hnedec_pkg::CH_AMP);
				send_byte(hnedec_pkg::CH_HASH);
				if (hex)
					send_x_marker();
				send_number(cp, hex);
				send_byte(hnedec_pkg::CH_SEMI);
			end else if (kind < 60) begin
				// A reference followed by an arbitrary byte, which usually cuts it short.
				hex = 1'($urandom_range(0, 1));
				send_byte(hnedec_pkg::CH_AMP);
				send_byte(hnedec_pkg::CH_HASH);
				if (hex)
					send_x_marker();
				if ($urandom_range(0, 1) != 0)
					send_number($urandom_range(0, 'hFFFF), hex);
				send_byte(8'($urandom_range(0, 255)));
			end else if (kind < 68) begin
				send_byte(hnedec_pkg::CH_AMP);
				repeat ($urandom_range(2, 5))
					send_byte(CH_LOW_A + 8'($urandom_range(0, 25)));
				send_byte(hnedec_pkg::CH_SEMI);
			end else if (kind < 93) begin
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				send_byte($urandom_range(0, 1) != 0 ? 8'h00 : sb.term);
			end
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_terminator(input logic [7:0] v);
		wait_drained();
		cfg_data <= v;
		cfg_we   <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_terminator(v);
		settings_used++;
	endtask

	initial begin
		logic [7:0] opening[$];
		// Empty reference, saturating hex with mixed case, x after a digit, then
		// a pending '&' and '&#' flushed by the zero word and the quote.
		opening = '{hnedec_pkg::CH_AMP, hnedec_pkg::CH_HASH, hnedec_pkg::CH_SEMI,
			hnedec_pkg::CH_AMP, hnedec_pkg::CH_HASH, hnedec_pkg::CH_LOW_X,
			8'h66, 8'h46, 8'h66, 8'h46, 8'h66, 8'h46, hnedec_pkg::CH_SEMI,
			hnedec_pkg::CH_AMP, hnedec_pkg::CH_HASH, 8'h31, hnedec_pkg::CH_LOW_X,
			hnedec_pkg::CH_AMP, 8'h00,
			hnedec_pkg::CH_AMP, hnedec_pkg::CH_HASH, hnedec_pkg::TERM_RESET,
			8'hFF, 8'h80};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening[i])
			send_byte(opening[i]);
		write_terminator(8'h27);
		run_random_phase(30);
		write_terminator(8'hFF);
		run_random_phase(30);
		write_terminator(8'h00);
		run_random_phase(30);
		write_terminator(hnedec_pkg::CH_AMP);
		run_random_phase(25);
		write_terminator(8'h37);
		run_random_phase(25);
		write_terminator(hnedec_pkg::TERM_RESET);
		allow_idle = 1'b0;
		run_random_phase(40);
		wait_drained();
		sb.check_drained();
		$display("Sent %0d input bytes under %0d terminator values and checked %0d result words.",
			bytes_sent, settings_used, sb.checked);
		if (sb.errors == 0)
			$display("html_numeric_entity_utf8_decoder_core: match");
		else
			$display("html_numeric_entity_utf8_decoder_core: mismatch");
		$finish;
	end

endmodule
